// ===== design/smiles_syntax_checker_unit_defines.svh =====
// Assertion macros used by the port-level checker file.
`ifndef SMILES_SYNTAX_CHECKER_UNIT_DEFINES_SVH
`define SMILES_SYNTAX_CHECKER_UNIT_DEFINES_SVH

// Property sampled on clk, off while rst is high.
`define SSC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ssc assertion failed");

// Property sampled on clk, also checked during reset.
`define SSC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ssc assertion failed during reset");

`endif

// ===== design/ssc_pkg.sv =====
// Types, codes and constants of the SMILES syntax checker.
package ssc_pkg;

  localparam int RING_SLOTS_DEF = 100;
  localparam int RING_GROUP     = 10;
  localparam int RING_NUM_W     = 7;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_NESTED     = 4'd1;
  localparam logic [3:0] ST_STRAY      = 4'd2;
  localparam logic [3:0] ST_DOT_BOND   = 4'd3;
  localparam logic [3:0] ST_PAREN_BOND = 4'd4;
  localparam logic [3:0] ST_DOUBLE     = 4'd5;
  localparam logic [3:0] ST_ENDS_BOND  = 4'd6;
  localparam logic [3:0] ST_UNMATCHED  = 4'd7;
  localparam logic [3:0] ST_RING_OPEN  = 4'd8;
  localparam logic [3:0] ST_BAD_RING   = 4'd9;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_TENS  = 3'b010,
    PH_UNITS = 3'b100
  } pct_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  typedef struct packed {
    logic [3:0]            status;
    logic [RING_NUM_W-1:0] ring_number;
  } result_req_t;

  typedef struct packed {
    logic [3:0] status;
    logic       scan_rings;
  } snap_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== design/ssc_char_stage.sv =====
// Input register, per-character state update and end-of-string snapshot.
module ssc_char_stage #(
  parameter int RING_SLOTS = ssc_pkg::RING_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_ready,
  input  ssc_pkg::char_req_t      char_req,
  output logic                    snap_valid,
  input  logic                    snap_ready,
  output ssc_pkg::snap_t          snap,
  output logic [RING_SLOTS-1:0]   snap_parity
);

  logic                          s0_valid;
  ssc_pkg::char_req_t            s0_req;
  logic                          s0_go;
  logic                          s1_free;

  logic                          inside_bracket;
  logic                          after_bond;
  logic [RING_SLOTS-1:0]         ring_parity;
  ssc_pkg::pct_phase_t           phase;
  logic [3:0]                    pct_tens;
  logic [3:0]                    err;

  logic                          inside_bracket_next;
  logic                          after_bond_next;
  logic [RING_SLOTS-1:0]         ring_parity_next;
  ssc_pkg::pct_phase_t           phase_next;
  logic [3:0]                    pct_tens_next;
  logic [3:0]                    err_next;
  ssc_pkg::snap_t                snap_next;

  logic [7:0]                    c;
  logic                          digit;
  logic [3:0]                    dval;
  logic                          bond;
  logic                          tog_en;
  logic [ssc_pkg::RING_NUM_W-1:0] tog_idx;
  logic [ssc_pkg::RING_NUM_W-1:0] pct_num;

  assign s1_free    = !snap_valid || snap_ready;
  assign s0_go      = s0_valid && (!s0_req.last || s1_free);
  assign char_ready = !s0_valid || s0_go;

  always_comb begin
    c       = s0_req.ch;
    digit   = ssc_pkg::is_digit(c);
    dval    = c[3:0];
    pct_num = {pct_tens, 3'b000} + 7'({pct_tens, 1'b0}) + 7'(dval);
    bond    = (!inside_bracket && (c == ssc_pkg::CH_DASH)) ||
              (c == ssc_pkg::CH_EQ) || (c == ssc_pkg::CH_HASH) ||
              (c == ssc_pkg::CH_COLON) || (c == ssc_pkg::CH_SLASH) ||
              (c == ssc_pkg::CH_BSLASH);

    inside_bracket_next = inside_bracket;
    after_bond_next     = after_bond;
    phase_next          = phase;
    pct_tens_next       = pct_tens;
    err_next            = err;
    tog_en              = 1'b0;
    tog_idx             = '0;

    if (err == ssc_pkg::ST_OK) begin
      case (phase)
        ssc_pkg::PH_TENS: begin
          if (!digit) begin
            err_next = ssc_pkg::ST_BAD_RING;
          end else begin
            pct_tens_next = dval;
            phase_next    = ssc_pkg::PH_UNITS;
          end
        end
        ssc_pkg::PH_UNITS: begin
          phase_next = ssc_pkg::PH_IDLE;
          if (!digit) begin
            err_next = ssc_pkg::ST_BAD_RING;
          end else begin
            after_bond_next = 1'b0;
            if (pct_num < 7'(RING_SLOTS)) begin
              tog_en  = 1'b1;
              tog_idx = pct_num;
            end else begin
              err_next = ssc_pkg::ST_BAD_RING;
            end
          end
        end
        default: begin
          if (digit && !inside_bracket) begin
            tog_en  = 1'b1;
            tog_idx = 7'(dval);
          end
          if ((c == ssc_pkg::CH_PCT) && !inside_bracket) begin
            phase_next = ssc_pkg::PH_TENS;
          end else if ((c == ssc_pkg::CH_LBRACK) && inside_bracket) begin
            err_next = ssc_pkg::ST_NESTED;
          end else if ((c == ssc_pkg::CH_RBRACK) && !inside_bracket) begin
            err_next = ssc_pkg::ST_STRAY;
          end else begin
            if (c == ssc_pkg::CH_LBRACK) inside_bracket_next = 1'b1;
            if (c == ssc_pkg::CH_RBRACK) inside_bracket_next = 1'b0;
            if ((c == ssc_pkg::CH_DOT) && after_bond) begin
              err_next = ssc_pkg::ST_DOT_BOND;
            end else if (((c == ssc_pkg::CH_LPAREN) || (c == ssc_pkg::CH_RPAREN)) &&
                         after_bond) begin
              err_next = ssc_pkg::ST_PAREN_BOND;
            end else if (bond) begin
              if (after_bond) err_next = ssc_pkg::ST_DOUBLE;
              else after_bond_next = 1'b1;
            end else begin
              after_bond_next = 1'b0;
            end
          end
        end
      endcase
    end

    for (int i = 0; i < RING_SLOTS; i++) begin
      ring_parity_next[i] = ring_parity[i] ^ (tog_en && (tog_idx == 7'(i)));
    end

    snap_next.scan_rings = 1'b0;
    if (err_next != ssc_pkg::ST_OK) begin
      snap_next.status = err_next;
    end else if (phase_next != ssc_pkg::PH_IDLE) begin
      snap_next.status = ssc_pkg::ST_BAD_RING;
    end else if (after_bond_next) begin
      snap_next.status = ssc_pkg::ST_ENDS_BOND;
    end else if (inside_bracket_next) begin
      snap_next.status = ssc_pkg::ST_UNMATCHED;
    end else begin
      snap_next.status     = ssc_pkg::ST_OK;
      snap_next.scan_rings = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (char_ready) begin
      s0_valid <= char_valid;
    end
    if (char_valid && char_ready) begin
      s0_req <= char_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s0_go && s0_req.last)) begin
      inside_bracket <= 1'b0;
      after_bond     <= 1'b0;
      ring_parity    <= '0;
      phase          <= ssc_pkg::PH_IDLE;
      pct_tens       <= '0;
      err            <= ssc_pkg::ST_OK;
    end else if (s0_go) begin
      inside_bracket <= inside_bracket_next;
      after_bond     <= after_bond_next;
      ring_parity    <= ring_parity_next;
      phase          <= phase_next;
      pct_tens       <= pct_tens_next;
      err            <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (s0_go && s0_req.last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
    if (s0_go && s0_req.last) begin
      snap        <= snap_next;
      snap_parity <= ring_parity_next;
    end
  end

endmodule

// ===== design/ssc_ring_scan.sv =====
// Two-stage lowest-open-ring search and result register.
module ssc_ring_scan #(
  parameter int RING_SLOTS = ssc_pkg::RING_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  snap_valid,
  output logic                  snap_ready,
  input  ssc_pkg::snap_t        snap,
  input  logic [RING_SLOTS-1:0] snap_parity,
  output logic                  result_valid,
  input  logic                  result_ready,
  output ssc_pkg::result_req_t  result_req
);

  localparam int GW   = ssc_pkg::RING_GROUP;
  localparam int NG   = (RING_SLOTS + GW - 1) / GW;
  localparam int PADW = NG * GW;
  localparam int NW   = ssc_pkg::RING_NUM_W;

  logic [PADW-1:0]     pad;
  logic [NG-1:0]       grp_any_next;
  logic [NW-1:0]       grp_num_next [NG];

  logic                s2_valid;
  ssc_pkg::snap_t      s2_snap;
  logic [NG-1:0]       grp_any;
  logic [NW-1:0]       grp_num [NG];
  logic                s2_free;
  logic                s3_free;

  logic                found;
  logic [NW-1:0]       low_num;
  ssc_pkg::result_req_t result_next;

  assign pad        = PADW'(snap_parity);
  assign s3_free    = !result_valid || result_ready;
  assign s2_free    = !s2_valid || s3_free;
  assign snap_ready = s2_free;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_next[g] = |pad[g*GW +: GW];
      grp_num_next[g] = '0;
      for (int k = GW - 1; k >= 0; k--) begin
        if (pad[g*GW + k]) grp_num_next[g] = NW'(g*GW + k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= snap_valid;
    end
    if (s2_free && snap_valid) begin
      s2_snap <= snap;
      grp_any <= grp_any_next;
      grp_num <= grp_num_next;
    end
  end

  always_comb begin
    found   = 1'b0;
    low_num = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found   = 1'b1;
        low_num = grp_num[g];
      end
    end
    if (s2_snap.scan_rings && found) begin
      result_next.status      = ssc_pkg::ST_RING_OPEN;
      result_next.ring_number = low_num;
    end else begin
      result_next.status      = s2_snap.status;
      result_next.ring_number = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s3_free) begin
      result_valid <= s2_valid;
    end
    if (s3_free && s2_valid) begin
      result_req <= result_next;
    end
  end

endmodule

// ===== design/smiles_syntax_checker_unit.sv =====
// Top level of the SMILES syntax checker.
// Usage:
//   char channel: one ASCII character per request (char_req.ch), with
//   char_req.last set on the final character of a string.
//   result channel: one request per string, given for the character marked
//   last: status code and, for an open ring, the lowest open ring number.
//   Characters not marked last produce no result.
// Timing: a character is taken every cycle when the result side is not
//   stalled. A string's result passes the input register, state update
//   with snapshot, per-group ring search and final ring select into the
//   result register.
// Reset: rst (synchronous) clears the pipeline and all string state.
//   After the last character all string state returns to reset values.
// Stall: while result_ready is low the result register holds; characters
//   not marked last keep flowing, and up to three strings may complete
//   into the pipeline before char_ready drops.
module smiles_syntax_checker_unit #(
  parameter int RING_SLOTS = ssc_pkg::RING_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_ready,
  input  ssc_pkg::char_req_t   char_req,
  output logic                 result_valid,
  input  logic                 result_ready,
  output ssc_pkg::result_req_t result_req
);

  logic                  snap_valid;
  logic                  snap_ready;
  ssc_pkg::snap_t        snap;
  logic [RING_SLOTS-1:0] snap_parity;

  ssc_char_stage #(
    .RING_SLOTS (RING_SLOTS)
  ) u_char (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_req    (char_req),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap        (snap),
    .snap_parity (snap_parity)
  );

  ssc_ring_scan #(
    .RING_SLOTS (RING_SLOTS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .snap_parity  (snap_parity),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_req   (result_req)
  );

endmodule

// ===== design/ssc_checker.sv =====
// Port-level checker for the SMILES syntax checker, with its bind.
`include "smiles_syntax_checker_unit_defines.svh"

module ssc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_ready,
  input ssc_pkg::result_req_t result_req
);

  logic not_ring_open;

  assign not_ring_open = (result_req.status != ssc_pkg::ST_RING_OPEN);

  `SSC_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid)
  `SSC_ASSERT(a_hold_valid, result_valid && !result_ready |=> result_valid)
  `SSC_ASSERT(a_hold_req, result_valid && !result_ready |=> $stable(result_req))
  `SSC_ASSERT(a_ring_zero, result_valid && not_ring_open |-> (result_req.ring_number == '0))
  `SSC_ASSERT(a_status_range, result_valid |-> (result_req.status <= ssc_pkg::ST_BAD_RING))

endmodule

bind smiles_syntax_checker_unit ssc_checker u_ssc_checker (.*);

// ===== dv/tb.sv =====
// Testbench for the SMILES syntax checker: queued character driver, result monitor, predictor.
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS       = ssc_pkg::RING_SLOTS_DEF;
  localparam int RNW         = ssc_pkg::RING_NUM_W;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 1000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 char_valid = 1'b0;
  logic                 char_ready;
  ssc_pkg::char_req_t   char_req = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  ssc_pkg::result_req_t result_req;

  ssc_pkg::char_req_t   char_queue[$];
  ssc_pkg::result_req_t results_due[$];
  logic [7:0]           str[$];
  int                   fail_count = 0;
  int                   cycle_count = 0;
  int                   total_chars = 0;
  int                   chars_taken = 0;

  // predictor state
  logic                 in_brk;
  logic                 bond_pend;
  logic [SLOTS-1:0]     parity;
  ssc_pkg::pct_phase_t  phase;
  logic [3:0]           tens;
  logic [3:0]           err;

  smiles_syntax_checker_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_req    (char_req),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_req  (result_req)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic num_char(input logic [7:0] c);
    return (c >= ssc_pkg::CH_ZERO) && (c <= ssc_pkg::CH_NINE);
  endfunction

  function automatic void clear_string_state();
    in_brk = 1'b0;
    bond_pend = 1'b0;
    parity = '0;
    phase = ssc_pkg::PH_IDLE;
    tens = 4'd0;
    err = ssc_pkg::ST_OK;
  endfunction

  function automatic void flip_ring(input logic [6:0] n);
    if (int'(n) < SLOTS) parity[n] = ~parity[n];
    else err = ssc_pkg::ST_BAD_RING;
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    logic bond;
    logic [6:0] n;
    if (phase == ssc_pkg::PH_TENS) begin
      if (!num_char(c)) begin
        err = ssc_pkg::ST_BAD_RING;
      end else begin
        tens = 4'(c - ssc_pkg::CH_ZERO);
        phase = ssc_pkg::PH_UNITS;
      end
      return;
    end
    if (phase == ssc_pkg::PH_UNITS) begin
      phase = ssc_pkg::PH_IDLE;
      if (!num_char(c)) begin
        err = ssc_pkg::ST_BAD_RING;
        return;
      end
      n = 7'(tens) * 7'd10 + 7'(c - ssc_pkg::CH_ZERO);
      flip_ring(n);
      bond_pend = 1'b0;
      return;
    end
    if (num_char(c) && !in_brk) flip_ring(7'(c - ssc_pkg::CH_ZERO));
    if (err != ssc_pkg::ST_OK) return;
    if (c == ssc_pkg::CH_PCT && !in_brk) begin
      phase = ssc_pkg::PH_TENS;
      return;
    end
    if (c == ssc_pkg::CH_LBRACK) begin
      if (in_brk) begin
        err = ssc_pkg::ST_NESTED;
        return;
      end
      in_brk = 1'b1;
    end
    if (c == ssc_pkg::CH_RBRACK) begin
      if (!in_brk) begin
        err = ssc_pkg::ST_STRAY;
        return;
      end
      in_brk = 1'b0;
    end
    if (c == ssc_pkg::CH_DOT && bond_pend) begin
      err = ssc_pkg::ST_DOT_BOND;
      return;
    end
    if ((c == ssc_pkg::CH_LPAREN || c == ssc_pkg::CH_RPAREN) && bond_pend) begin
      err = ssc_pkg::ST_PAREN_BOND;
      return;
    end
    bond = (!in_brk && c == ssc_pkg::CH_DASH) || c == ssc_pkg::CH_EQ ||
           c == ssc_pkg::CH_HASH || c == ssc_pkg::CH_COLON ||
           c == ssc_pkg::CH_SLASH || c == ssc_pkg::CH_BSLASH;
    if (bond) begin
      if (bond_pend) begin
        err = ssc_pkg::ST_DOUBLE;
        return;
      end
      bond_pend = 1'b1;
    end else begin
      bond_pend = 1'b0;
    end
  endfunction

  function automatic void predict_char(input ssc_pkg::char_req_t r);
    ssc_pkg::result_req_t res;
    logic found;
    if (err == ssc_pkg::ST_OK) scan_char(r.ch);
    if (!r.last) return;
    res = '0;
    found = 1'b0;
    if (err != ssc_pkg::ST_OK) begin
      res.status = err;
    end else if (phase != ssc_pkg::PH_IDLE) begin
      res.status = ssc_pkg::ST_BAD_RING;
    end else if (bond_pend) begin
      res.status = ssc_pkg::ST_ENDS_BOND;
    end else if (in_brk) begin
      res.status = ssc_pkg::ST_UNMATCHED;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && parity[i]) begin
          found = 1'b1;
          res.status = ssc_pkg::ST_RING_OPEN;
          res.ring_number = RNW'(i);
        end
      end
    end
    results_due.insert(results_due.size(), res);
    clear_string_state();
  endfunction

  // stimulus helpers
  task automatic add_byte(input logic [7:0] b);
    str.insert(str.size(), b);
  endtask

  task automatic send_str();
    ssc_pkg::char_req_t r;
    for (int i = 0; i < str.size(); i++) begin
      r.ch = str[i];
      r.last = (i == str.size() - 1);
      char_queue.insert(char_queue.size(), r);
    end
    str.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(8'(s[i]));
    send_str();
  endtask

  task automatic put_atom();
    string s;
    s = "CNOScnPF";
    add_byte(8'(s[$urandom_range(0, s.len() - 1)]));
  endtask

  task automatic put_ring(input int n);
    if (n < 10 && $urandom_range(0, 1)) begin
      add_byte(ssc_pkg::CH_ZERO + 8'(n));
    end else begin
      add_byte(ssc_pkg::CH_PCT);
      add_byte(ssc_pkg::CH_ZERO + 8'(n / 10));
      add_byte(ssc_pkg::CH_ZERO + 8'(n % 10));
    end
  endtask

  task automatic gen_molecule();
    int ntok;
    int n;
    int pos;
    int open_rings[$];
    string bonds;
    string junk;
    bonds = "-=#:/\\";
    junk = "[]().-=#:/\\%0123456789C";
    if ($urandom_range(0, 9) == 0) begin
      ntok = $urandom_range(1, 8);
      for (int k = 0; k < ntok; k++) begin
        if ($urandom_range(0, 1)) add_byte(8'($urandom_range(0, 255)));
        else add_byte(8'(junk[$urandom_range(0, junk.len() - 1)]));
      end
      send_str();
      return;
    end
    ntok = $urandom_range(1, 6);
    for (int k = 0; k < ntok; k++) begin
      case ($urandom_range(0, 11))
        0, 1, 2: put_atom();
        3, 4: begin
          add_byte(8'(bonds[$urandom_range(0, bonds.len() - 1)]));
          put_atom();
        end
        5, 6: begin
          if (open_rings.size() > 0 && $urandom_range(0, 1)) begin
            n = open_rings.pop_front();
          end else begin
            n = $urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom_range(0, 99);
            open_rings.insert(open_rings.size(), n);
          end
          put_ring(n);
        end
        7, 8: begin
          add_byte(ssc_pkg::CH_LBRACK);
          if ($urandom_range(0, 1)) add_byte(ssc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          put_atom();
          case ($urandom_range(0, 3))
            0: add_byte(ssc_pkg::CH_DASH);
            1: add_byte(8'h2b);
            2: add_byte(8'h48);
            default: ;
          endcase
          if ($urandom_range(0, 1)) add_byte(ssc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          add_byte(ssc_pkg::CH_RBRACK);
        end
        9, 10: begin
          add_byte(ssc_pkg::CH_LPAREN);
          if ($urandom_range(0, 1))
            add_byte(8'(bonds[$urandom_range(0, bonds.len() - 1)]));
          put_atom();
          add_byte(ssc_pkg::CH_RPAREN);
        end
        default: begin
          add_byte(ssc_pkg::CH_DOT);
          put_atom();
        end
      endcase
    end
    while (open_rings.size() > 0 && $urandom_range(0, 4) != 0) put_ring(open_rings.pop_front());
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, str.size() - 1);
      case ($urandom_range(0, 2))
        0: str[pos] = 8'($urandom_range(0, 255));
        1: while (str.size() > pos + 1) void'(str.pop_back());
        default: str.insert(pos, 8'(junk[$urandom_range(0, junk.len() - 1)]));
      endcase
    end
    send_str();
  endtask

  // character driver
  int  char_wait = 0;
  bit  char_calm = 1'b0;
  bit  char_busy;

  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      char_busy = char_valid;
      if (char_valid && char_ready) begin
        predict_char(char_req);
        chars_taken++;
        char_busy = 1'b0;
        if ($urandom_range(0, 99) < 3) char_calm = !char_calm;
        char_wait = char_calm ? 0 : $urandom_range(0, 5);
      end
      if (!char_busy) begin
        if (char_wait > 0) begin
          char_wait--;
        end else if (char_queue.size() > 0) begin
          char_req <= char_queue.pop_front();
          char_busy = 1'b1;
        end
      end
      char_valid <= char_busy;
    end
  end

  // result monitor
  int                   res_wait = 0;
  bit                   res_calm = 1'b0;
  ssc_pkg::result_req_t res_exp;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: status %0d ring_number %0d",
                 result_req.status, result_req.ring_number);
          fail_count++;
        end else begin
          res_exp = results_due.pop_front();
          if (result_req.status !== res_exp.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   res_exp.status, result_req.status);
            fail_count++;
          end
          if (result_req.ring_number !== res_exp.ring_number) begin
            $error("ring_number mismatch: expected %0d, actual %0d",
                   res_exp.ring_number, result_req.ring_number);
            fail_count++;
          end
        end
        if ($urandom_range(0, 99) < 3) res_calm = !res_calm;
        res_wait = res_calm ? 0 : $urandom_range(0, 5);
      end
      if (res_wait > 0) begin
        res_wait--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    clear_string_state();
    // directed strings: one per status plus edge characters
    add_text("C");
    add_text("[[");
    add_text("]");
    add_text("-.");
    add_text("=(");
    add_text("#/");
    add_text("\\");
    add_text("[");
    add_text("12");
    add_text("%");
    add_text("%x");
    add_text("%47");
    add_text("[-]");
    add_byte(8'h00);
    send_str();
    add_byte(8'hff);
    send_str();
    while (char_queue.size() < ITEM_TARGET) gen_molecule();
    total_chars = char_queue.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (chars_taken < total_chars || results_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("results still expected at end: %0d", results_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
